>>> design/bilinear_nearest_image_scaler_unit_defines.svh
// Assertion macros used by the scaler top level.
`ifndef BILINEAR_NEAREST_IMAGE_SCALER_UNIT_DEFINES_SVH
`define BILINEAR_NEAREST_IMAGE_SCALER_UNIT_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define BNS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("scaler check failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define BNS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("scaler check failed");

`endif

>>> design/bns_pkg.sv
// Types, codes and blend function of the image scaler.
package bns_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIVH_GO,
    ST_DIVH_WAIT,
    ST_DIVV_GO,
    ST_DIVV_WAIT,
    ST_FETCH,
    ST_DRAIN,
    ST_BLEND,
    ST_EMIT
  } bns_state_e;

  localparam logic MODE_LOAD    = 1'b0;
  localparam logic MODE_REQUEST = 1'b1;

  localparam logic [2:0] REG_SRC_W   = 3'd0;
  localparam logic [2:0] REG_SRC_H   = 3'd1;
  localparam logic [2:0] REG_DST_W   = 3'd2;
  localparam logic [2:0] REG_DST_H   = 3'd3;
  localparam logic [2:0] REG_NEAREST = 3'd4;

  localparam logic [7:0]  ALPHA_OPAQUE = 8'hFF;
  localparam logic [8:0]  WEIGHT_ONE   = 9'd256;
  localparam int          FRAC_BITS    = 16;

  // Blends red, green and blue of two pixels with weight t out of 256.
  function automatic logic [31:0] blend_rgb(input logic [31:0] a, input logic [31:0] b,
                                            input logic [8:0] t);
    logic [8:0]  it;
    logic [16:0] r, g, bl;
    it = WEIGHT_ONE - t;
    r  = 17'(a[23:16] * it) + 17'(b[23:16] * t);
    g  = 17'(a[15:8] * it) + 17'(b[15:8] * t);
    bl = 17'(a[7:0] * it) + 17'(b[7:0] * t);
    return {ALPHA_OPAQUE, r[15:8], g[15:8], bl[15:8]};
  endfunction

endpackage

>>> design/bilinear_nearest_image_scaler_unit.sv
// Top level of the nearest / bilinear ARGB8888 image scaler.
// A load word (mode 0) writes one source pixel into the single-port source RAM;
// busy_o stays low. A request word (mode 1) returns the next destination pixel
// on valid_o for one cycle. In bilinear mode the four neighbor texels are read one
// per cycle from the single RAM port and blended in two registered stages; nearest
// mode reads one texel. The first request of a frame first runs two shared serial
// divisions for the 16.16 steps. Results cannot be held off by the receiver.
// Register writes take effect at the next frame start.
`include "bilinear_nearest_image_scaler_unit_defines.svh"
module bilinear_nearest_image_scaler_unit #(
  parameter int MAX_SRC_W   = 256,
  parameter int MAX_SRC_H   = 256,
  parameter int MAX_DST_DIM = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic        mode_i,
  input  logic [7:0]  load_x_i,
  input  logic [7:0]  load_y_i,
  input  logic [31:0] load_pixel_i,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [12:0] cfg_data_i,
  output logic        valid_o,
  output logic [31:0] out_pixel_o,
  output logic [11:0] out_x_o,
  output logic [11:0] out_y_o,
  output logic        row_end_o,
  output logic        frame_end_o
);
  import bns_pkg::*;

  localparam int SWB   = $clog2(MAX_SRC_W + 1);
  localparam int SHB   = $clog2(MAX_SRC_H + 1);
  localparam int SB    = (SWB > SHB) ? SWB : SHB;
  localparam int NW    = SB + FRAC_BITS;
  localparam int TWB   = $clog2(MAX_DST_DIM + 1);
  localparam int CW    = $clog2(MAX_DST_DIM);
  localparam int DEPTH = MAX_SRC_W * MAX_SRC_H;
  localparam int AW    = $clog2(DEPTH);

  bns_state_e state_q, state_d;

  logic [8:0]  cfg_sw_q, cfg_sh_q;
  logic [12:0] cfg_tw_q, cfg_th_q;
  logic        cfg_nearest_q;

  logic [SWB-1:0] cur_sw_q, cur_sw_d;
  logic [SHB-1:0] cur_sh_q, cur_sh_d;
  logic [TWB-1:0] cur_tw_q, cur_tw_d, cur_th_q, cur_th_d;
  logic           cur_nearest_q, cur_nearest_d;

  logic [CW-1:0]  col_q, col_d, row_q, row_d;
  logic [31:0]    hpos_q, hpos_d, vpos_q, vpos_d, hstep_q, hstep_d, vstep_q, vstep_d;
  logic [1:0]     k_q, k_d;
  logic           rd_valid_q;
  logic [1:0]     rd_idx_q;
  logic [31:0]    tex_q [4];
  logic [31:0]    top_q, bot_q;

  logic           valid_q, valid_d, rend_q, rend_d, fend_q, fend_d;
  logic [31:0]    pix_q, pix_d;
  logic [11:0]    ox_q, ox_d, oy_q, oy_d;

  logic           ram_we;
  logic [AW-1:0]  ram_addr;
  logic [31:0]    ram_rdata;

  logic           div_start, div_busy, div_done;
  logic [NW-1:0]  div_num, div_quo;
  logic [TWB-1:0] div_den;

  logic [31:0] sw32, sh32, tw32, th32, ux_raw, uy_raw, ux0, ux1, uy0, uy1, ax, ay;
  logic [31:0] col32, row32;
  logic [8:0]  tu, tv;
  logic        accept, rend, fend;

  assign accept = start_i && (state_q == ST_IDLE);

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_sw_q      <= 9'd256;
      cfg_sh_q      <= 9'd256;
      cfg_tw_q      <= 13'd256;
      cfg_th_q      <= 13'd256;
      cfg_nearest_q <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_SRC_W:   cfg_sw_q      <= cfg_data_i[8:0];
        REG_SRC_H:   cfg_sh_q      <= cfg_data_i[8:0];
        REG_DST_W:   cfg_tw_q      <= cfg_data_i;
        REG_DST_H:   cfg_th_q      <= cfg_data_i;
        REG_NEAREST: cfg_nearest_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Dimensions are clamped to 1..maximum when latched at frame start.
  always_comb begin
    sw32 = 32'(cfg_sw_q);
    sh32 = 32'(cfg_sh_q);
    tw32 = 32'(cfg_tw_q);
    th32 = 32'(cfg_th_q);
    if (sw32 == 32'd0) sw32 = 32'd1;
    if (sw32 > 32'(MAX_SRC_W)) sw32 = 32'(MAX_SRC_W);
    if (sh32 == 32'd0) sh32 = 32'd1;
    if (sh32 > 32'(MAX_SRC_H)) sh32 = 32'(MAX_SRC_H);
    if (tw32 == 32'd0) tw32 = 32'd1;
    if (tw32 > 32'(MAX_DST_DIM)) tw32 = 32'(MAX_DST_DIM);
    if (th32 == 32'd0) th32 = 32'd1;
    if (th32 > 32'(MAX_DST_DIM)) th32 = 32'(MAX_DST_DIM);
  end

  // Texel coordinates, with right and bottom neighbors clamped to the last column and row.
  always_comb begin
    ux_raw = {16'd0, hpos_q[31:16]};
    uy_raw = {16'd0, vpos_q[31:16]};
    ux0 = (ux_raw >= 32'(cur_sw_q)) ? 32'(cur_sw_q) - 32'd1 : ux_raw;
    uy0 = (uy_raw >= 32'(cur_sh_q)) ? 32'(cur_sh_q) - 32'd1 : uy_raw;
    ux1 = (ux0 + 32'd1 >= 32'(cur_sw_q)) ? 32'(cur_sw_q) - 32'd1 : ux0 + 32'd1;
    uy1 = (uy0 + 32'd1 >= 32'(cur_sh_q)) ? 32'(cur_sh_q) - 32'd1 : uy0 + 32'd1;
    ax  = k_q[0] ? ux1 : ux0;
    ay  = k_q[1] ? uy1 : uy0;
    tu  = {1'b0, hpos_q[15:8]} + {8'd0, hpos_q[15]};
    tv  = {1'b0, vpos_q[15:8]} + {8'd0, vpos_q[15]};
    col32 = 32'(col_q);
    row32 = 32'(row_q);
    rend  = (col32 + 32'd1 >= 32'(cur_tw_q));
    fend  = rend && (row32 + 32'd1 >= 32'(cur_th_q));
  end

  always_comb begin
    state_d       = state_q;
    cur_sw_d      = cur_sw_q;
    cur_sh_d      = cur_sh_q;
    cur_tw_d      = cur_tw_q;
    cur_th_d      = cur_th_q;
    cur_nearest_d = cur_nearest_q;
    col_d   = col_q;
    row_d   = row_q;
    hpos_d  = hpos_q;
    vpos_d  = vpos_q;
    hstep_d = hstep_q;
    vstep_d = vstep_q;
    k_d     = k_q;
    valid_d = 1'b0;
    pix_d   = pix_q;
    ox_d    = ox_q;
    oy_d    = oy_q;
    rend_d  = rend_q;
    fend_d  = fend_q;
    ram_we  = 1'b0;
    ram_addr  = AW'(ay * 32'(MAX_SRC_W) + ax);
    div_start = 1'b0;
    div_num   = NW'({cur_sw_q, 16'd0});
    div_den   = cur_tw_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          if (mode_i == MODE_LOAD) begin
            ram_addr = AW'(32'(load_y_i) * 32'(MAX_SRC_W) + 32'(load_x_i));
            ram_we   = (32'(load_x_i) < 32'(MAX_SRC_W)) && (32'(load_y_i) < 32'(MAX_SRC_H));
          end else begin
            k_d = 2'd0;
            if (col_q == '0 && row_q == '0) begin
              cur_sw_d      = SWB'(sw32);
              cur_sh_d      = SHB'(sh32);
              cur_tw_d      = TWB'(tw32);
              cur_th_d      = TWB'(th32);
              cur_nearest_d = cfg_nearest_q;
              state_d       = ST_DIVH_GO;
            end else begin
              state_d = ST_FETCH;
            end
          end
        end
      end
      ST_DIVH_GO: begin
        div_start = 1'b1;
        state_d   = ST_DIVH_WAIT;
      end
      ST_DIVH_WAIT: begin
        if (div_done) begin
          hstep_d = 32'(div_quo);
          hpos_d  = cur_nearest_q ? 32'd0 : 32'(div_quo) >> 1;
          state_d = ST_DIVV_GO;
        end
      end
      ST_DIVV_GO: begin
        div_start = 1'b1;
        div_num   = NW'({cur_sh_q, 16'd0});
        div_den   = cur_th_q;
        state_d   = ST_DIVV_WAIT;
      end
      ST_DIVV_WAIT: begin
        if (div_done) begin
          vstep_d = 32'(div_quo);
          vpos_d  = cur_nearest_q ? 32'd0 : 32'(div_quo) >> 1;
          state_d = ST_FETCH;
        end
      end
      ST_FETCH: begin
        if (cur_nearest_q || k_q == 2'd3) begin
          state_d = ST_DRAIN;
        end else begin
          k_d = k_q + 2'd1;
        end
      end
      ST_DRAIN: begin
        state_d = cur_nearest_q ? ST_EMIT : ST_BLEND;
      end
      ST_BLEND: begin
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        valid_d = 1'b1;
        pix_d   = cur_nearest_q ? tex_q[0] : blend_rgb(top_q, bot_q, tv);
        ox_d    = col32[11:0];
        oy_d    = row32[11:0];
        rend_d  = rend;
        fend_d  = fend;
        if (fend) begin
          col_d = '0;
          row_d = '0;
        end else if (rend) begin
          col_d  = '0;
          row_d  = row_q + 1'b1;
          hpos_d = cur_nearest_q ? 32'd0 : hstep_q >> 1;
          vpos_d = vpos_q + vstep_q;
        end else begin
          col_d  = col_q + 1'b1;
          hpos_d = hpos_q + hstep_q;
        end
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      col_q      <= '0;
      row_q      <= '0;
      k_q        <= '0;
      rd_valid_q <= 1'b0;
      valid_q    <= 1'b0;
    end else begin
      state_q    <= state_d;
      col_q      <= col_d;
      row_q      <= row_d;
      k_q        <= k_d;
      rd_valid_q <= (state_q == ST_FETCH);
      valid_q    <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_sw_q      <= cur_sw_d;
    cur_sh_q      <= cur_sh_d;
    cur_tw_q      <= cur_tw_d;
    cur_th_q      <= cur_th_d;
    cur_nearest_q <= cur_nearest_d;
    hpos_q  <= hpos_d;
    vpos_q  <= vpos_d;
    hstep_q <= hstep_d;
    vstep_q <= vstep_d;
    rd_idx_q <= k_q;
    // Read data arrives in the cycle after its address was issued.
    if (rd_valid_q) begin
      tex_q[rd_idx_q] <= ram_rdata;
    end
    if (state_q == ST_BLEND) begin
      top_q <= blend_rgb(tex_q[0], tex_q[1], tu);
      bot_q <= blend_rgb(tex_q[2], tex_q[3], tu);
    end
    pix_q  <= pix_d;
    ox_q   <= ox_d;
    oy_q   <= oy_d;
    rend_q <= rend_d;
    fend_q <= fend_d;
  end

  bns_ram #(
    .WIDTH(32),
    .DEPTH(DEPTH)
  ) u_src_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(load_pixel_i),
    .rdata_o(ram_rdata)
  );

  bns_div #(
    .NW(NW),
    .DW(TWB)
  ) u_step_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (div_den),
    .busy_o (div_busy),
    .done_o (div_done),
    .quo_o  (div_quo)
  );

  assign busy_o      = (state_q != ST_IDLE);
  assign valid_o     = valid_q;
  assign out_pixel_o = pix_q;
  assign out_x_o     = ox_q;
  assign out_y_o     = oy_q;
  assign row_end_o   = rend_q;
  assign frame_end_o = fend_q;

  `BNS_ASSERT_IMP(a_ram_write_idle, clk_i, rst_ni, ram_we, state_q == ST_IDLE)
  `BNS_ASSERT_IMP(a_div_busy_blocks, clk_i, rst_ni, div_busy, busy_o)
  `BNS_ASSERT_NEXT(a_request_busy, clk_i, rst_ni, accept && mode_i == MODE_REQUEST, busy_o)
  `BNS_ASSERT_IMP(a_frame_end_row_end, clk_i, rst_ni, valid_o && frame_end_o, row_end_o)

endmodule

>>> design/bns_ram.sv
// Generic single-port synchronous RAM with registered read.
module bns_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

>>> design/bns_div.sv
// Restoring divider that produces one quotient bit per cycle.
module bns_div #(
  parameter int NW = 25,
  parameter int DW = 13
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic          busy_o,
  output logic          done_o,
  output logic [NW-1:0] quo_o
);

  localparam int CW = $clog2(NW + 1);

  logic          busy_q, busy_d, done_q, done_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [DW:0]   rem_q, rem_d, rem_sh;
  logic [NW-1:0] quo_q, quo_d;
  logic [DW-1:0] den_q, den_d;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    rem_sh = {rem_q[DW-1:0], quo_q[NW-1]};
    if (start_i && !busy_q) begin
      busy_d = 1'b1;
      cnt_d  = CW'(NW);
      rem_d  = '0;
      quo_d  = num_i;
      den_d  = den_i;
    end else if (busy_q) begin
      if (rem_sh >= {1'b0, den_q}) begin
        rem_d = rem_sh - {1'b0, den_q};
        quo_d = {quo_q[NW-2:0], 1'b1};
      end else begin
        rem_d = rem_sh;
        quo_d = {quo_q[NW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

>>> tb/bilinear_nearest_image_scaler_unit_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the image scaler: mirrors its state, predicts each pixel and compares.
module bilinear_nearest_image_scaler_unit_checker
  import bns_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_i,
  input  logic        mode_i,
  input  logic [7:0]  load_x_i,
  input  logic [7:0]  load_y_i,
  input  logic [31:0] load_pixel_i,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [12:0] cfg_data_i,
  input  logic        valid_i,
  input  logic [31:0] out_pixel_i,
  input  logic [11:0] out_x_i,
  input  logic [11:0] out_y_i,
  input  logic        row_end_i,
  input  logic        frame_end_i,
  output int          pending_o,
  output int          fail_count_o
);

  typedef struct packed {
    logic [31:0] pixel;
    logic [11:0] col;
    logic [11:0] row;
    logic        row_last;
    logic        frame_last;
  } dest_pixel_t;

  logic [31:0] texels [65536];
  dest_pixel_t pixel_q[$];

  logic [8:0]  src_w_reg, src_h_reg;
  logic [12:0] dst_w_reg, dst_h_reg;
  logic        nearest_reg;
  int unsigned cur_sw, cur_sh, cur_tw, cur_th;
  logic        cur_nearest;
  int unsigned col_cnt, row_cnt, hpos, vpos, hstep, vstep;
  int          fails;

  assign pending_o    = pixel_q.size();
  assign fail_count_o = fails;

  function automatic int unsigned clamp_size(int unsigned v, int unsigned hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic [31:0] mix_rgb(logic [31:0] a, logic [31:0] b, int unsigned t);
    int unsigned it, r, g, bl;
    it = 256 - t;
    r  = ((a[23:16] * it + b[23:16] * t) >> 8) & 8'hFF;
    g  = ((a[15:8] * it + b[15:8] * t) >> 8) & 8'hFF;
    bl = ((a[7:0] * it + b[7:0] * t) >> 8) & 8'hFF;
    return {8'hFF, r[7:0], g[7:0], bl[7:0]};
  endfunction

  function automatic int unsigned frac_weight(int unsigned pos);
    int unsigned f;
    f = (pos >> 8) & 8'hFF;
    return f + (f >> 7);
  endfunction

  function automatic logic [31:0] texel(int unsigned x, int unsigned y);
    return texels[y * 256 + x];
  endfunction

  task automatic latch_frame();
    cur_sw      = clamp_size(src_w_reg, 256);
    cur_sh      = clamp_size(src_h_reg, 256);
    cur_tw      = clamp_size(dst_w_reg, 4096);
    cur_th      = clamp_size(dst_h_reg, 4096);
    cur_nearest = nearest_reg;
    hstep       = (cur_sw << 16) / cur_tw;
    vstep       = (cur_sh << 16) / cur_th;
    hpos        = cur_nearest ? 0 : hstep >> 1;
    vpos        = cur_nearest ? 0 : vstep >> 1;
  endtask

  task automatic predict_pixel();
    int unsigned ux, uy, ux1, uy1, tu, tv;
    logic [31:0] top_px, bot_px;
    dest_pixel_t exp_px;
    if (col_cnt == 0 && row_cnt == 0) latch_frame();
    ux = hpos >> 16;
    uy = vpos >> 16;
    if (ux >= cur_sw) ux = cur_sw - 1;
    if (uy >= cur_sh) uy = cur_sh - 1;
    if (cur_nearest) begin
      exp_px.pixel = texel(ux, uy);
    end else begin
      tu  = frac_weight(hpos);
      tv  = frac_weight(vpos);
      ux1 = (ux + 1 >= cur_sw) ? cur_sw - 1 : ux + 1;
      uy1 = (uy + 1 >= cur_sh) ? cur_sh - 1 : uy + 1;
      top_px = mix_rgb(texel(ux, uy), texel(ux1, uy), tu);
      bot_px = mix_rgb(texel(ux, uy1), texel(ux1, uy1), tu);
      exp_px.pixel = mix_rgb(top_px, bot_px, tv);
    end
    exp_px.col        = col_cnt[11:0];
    exp_px.row        = row_cnt[11:0];
    exp_px.row_last   = (col_cnt + 1 >= cur_tw);
    exp_px.frame_last = exp_px.row_last && (row_cnt + 1 >= cur_th);
    pixel_q.push_back(exp_px);
    if (exp_px.frame_last) begin
      col_cnt = 0;
      row_cnt = 0;
    end else if (exp_px.row_last) begin
      col_cnt = 0;
      row_cnt++;
      hpos = cur_nearest ? 0 : hstep >> 1;
      vpos += vstep;
    end else begin
      col_cnt++;
      hpos += hstep;
    end
  endtask

  task automatic compare_pixel();
    dest_pixel_t exp_px, got_px;
    got_px = {out_pixel_i, out_x_i, out_y_i, row_end_i, frame_end_i};
    if (pixel_q.size() == 0) begin
      fails++;
      if (fails <= 10) $display("Unexpected pixel word: %p", got_px);
      return;
    end
    exp_px = pixel_q.pop_front();
    if (got_px !== exp_px) begin
      fails++;
      if (fails <= 10)
        $display("Pixel mismatch: expected %p, got %p", exp_px, got_px);
    end
  endtask

  initial fails = 0;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      src_w_reg   <= 9'd256;
      src_h_reg   <= 9'd256;
      dst_w_reg   <= 13'd256;
      dst_h_reg   <= 13'd256;
      nearest_reg <= 1'b1;
      col_cnt     = 0;
      row_cnt     = 0;
    end else begin
      if (valid_i) compare_pixel();
      if (start_i && !busy_i) begin
        if (mode_i == MODE_LOAD) texels[{load_y_i, load_x_i}] = load_pixel_i;
        else predict_pixel();
      end
      // Register writes only matter at the next frame start, so ordering here is harmless.
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_SRC_W:   src_w_reg   <= cfg_data_i[8:0];
          REG_SRC_H:   src_h_reg   <= cfg_data_i[8:0];
          REG_DST_W:   dst_w_reg   <= cfg_data_i;
          REG_DST_H:   dst_h_reg   <= cfg_data_i;
          REG_NEAREST: nearest_reg <= cfg_data_i[0];
          default: ;
        endcase
      end
    end
  end

endmodule

>>> tb/bilinear_nearest_image_scaler_unit_tb.sv
`timescale 1ns / 100ps
// Stimulus and verdict for the image scaler: loads, pixel requests and register phases.
module bilinear_nearest_image_scaler_unit_tb;
  import bns_pkg::*;

  localparam logic [2:0] REG_UNUSED = 3'd7;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int DRAIN_CYCLES = 120;

  logic        clk_i, rst_ni, start_i, mode_i, cfg_we_i;
  logic [7:0]  load_x_i, load_y_i;
  logic [31:0] load_pixel_i;
  logic [2:0]  cfg_index_i;
  logic [12:0] cfg_data_i;
  logic        busy_o, valid_o, row_end_o, frame_end_o;
  logic [31:0] out_pixel_o;
  logic [11:0] out_x_o, out_y_o;
  int          pending_pixels, fail_count, cycle_cnt, requests_sent;
  bit          texel_written [65536];

  bilinear_nearest_image_scaler_unit i_dut (.*);

  bilinear_nearest_image_scaler_unit_checker i_checker (
    .clk_i, .rst_ni, .start_i, .busy_i(busy_o), .mode_i, .load_x_i, .load_y_i,
    .load_pixel_i, .cfg_we_i, .cfg_index_i, .cfg_data_i, .valid_i(valid_o),
    .out_pixel_i(out_pixel_o), .out_x_i(out_x_o), .out_y_i(out_y_o),
    .row_end_i(row_end_o), .frame_end_i(frame_end_o),
    .pending_o(pending_pixels), .fail_count_o(fail_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial cycle_cnt = 0;
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(99);
    if (roll < 70) return 0;
    if (roll < 95) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  // Sends one word; returns at the falling edge after it was taken.
  task automatic send_word(logic m, logic [7:0] x, logic [7:0] y, logic [31:0] px,
                           bit no_gap);
    int gap;
    gap = no_gap ? 0 : pick_gap();
    if (gap > 0) begin
      start_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start_i      = 1'b1;
    mode_i       = m;
    load_x_i     = x;
    load_y_i     = y;
    load_pixel_i = px;
    forever begin
      @(posedge clk_i);
      if (!busy_o) break;
    end
    @(negedge clk_i);
    if (m == MODE_LOAD) texel_written[{y, x}] = 1'b1;
    else requests_sent++;
  endtask

  task automatic write_reg(logic [2:0] idx, logic [12:0] val);
    cfg_we_i    = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic wait_idle();
    start_i = 1'b0;
    while (pending_pixels != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  // One register setting: write all registers, fill the active source area,
  // then request whole frames with loads mixed in. A nonzero request cap stops
  // the phase early and leaves the frame unfinished.
  task automatic run_phase(logic [12:0] sw, logic [12:0] sh, logic [12:0] tw,
                           logic [12:0] th, logic nm, int frames, int load_pct,
                           int req_cap = 0);
    int unsigned w, h, fw, fh;
    bit burst;
    w  = (sw[8:0] == 0) ? 1 : (sw[8:0] > 256 ? 256 : sw[8:0]);
    h  = (sh[8:0] == 0) ? 1 : (sh[8:0] > 256 ? 256 : sh[8:0]);
    fw = (tw == 0) ? 1 : (tw > 4096 ? 4096 : tw);
    fh = (th == 0) ? 1 : (th > 4096 ? 4096 : th);
    wait_idle();
    write_reg(REG_SRC_W, sw);
    write_reg(REG_SRC_H, sh);
    write_reg(REG_DST_W, tw);
    write_reg(REG_DST_H, th);
    write_reg(REG_NEAREST, {12'd0, nm});
    write_reg(REG_UNUSED, 13'($urandom));
    for (int y = 0; y < h; y++)
      for (int x = 0; x < w; x++)
        if (!texel_written[y * 256 + x])
          send_word(MODE_LOAD, 8'(x), 8'(y), $urandom, 1'b0);
    burst = ($urandom_range(3) == 0);
    for (int n = 0; n < frames * fw * fh; n++) begin
      if (req_cap > 0 && n >= req_cap) break;
      if ($urandom_range(99) < load_pct)
        send_word(MODE_LOAD, 8'($urandom), 8'($urandom), $urandom, burst);
      send_word(MODE_REQUEST, 8'($urandom), 8'($urandom), $urandom, burst);
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    start_i = 1'b0;
    mode_i = MODE_LOAD;
    load_x_i = '0;
    load_y_i = '0;
    load_pixel_i = '0;
    cfg_we_i = 1'b0;
    cfg_index_i = REG_SRC_W;
    cfg_data_i = '0;
    requests_sent = 0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Extreme pixel values and corners of the store.
    send_word(MODE_LOAD, 8'd0, 8'd0, 32'h0000_0000, 1'b1);
    send_word(MODE_LOAD, 8'd1, 8'd0, 32'hFFFF_FFFF, 1'b1);
    send_word(MODE_LOAD, 8'd0, 8'd1, 32'hFFFF_FFFF, 1'b1);
    send_word(MODE_LOAD, 8'd1, 8'd1, 32'h0000_0000, 1'b1);
    send_word(MODE_LOAD, 8'd255, 8'd255, 32'hA5A5_5A5A, 1'b0);
    send_word(MODE_LOAD, 8'd255, 8'd0, 32'h5A5A_A5A5, 1'b0);
    send_word(MODE_LOAD, 8'd0, 8'd255, 32'h8000_0001, 1'b0);
    // Upscale of a 2x2 checker in both modes, and zero sizes used as one.
    run_phase(13'd2, 13'd2, 13'd5, 13'd3, 1'b0, 1, 0);
    run_phase(13'd2, 13'd2, 13'd3, 13'd2, 1'b1, 1, 0);
    run_phase(13'd0, 13'd0, 13'd0, 13'd0, 1'b0, 2, 0);
    // A full-width source row and a full-height source column.
    run_phase(13'd256, 13'd1, 13'd7, 13'd1, 1'b0, 1, 10);
    run_phase(13'd1, 13'd256, 13'd1, 13'd9, 1'b1, 1, 10);
    // An oversize source height clamps to the maximum.
    run_phase(13'd1, 13'd511, 13'd1, 13'd9, 1'b0, 1, 2);

    while (requests_sent < 700)
      run_phase(13'($urandom_range(1, 16)), 13'($urandom_range(1, 16)),
                13'($urandom_range(1, 24)), 13'($urandom_range(1, 12)),
                1'($urandom), $urandom_range(1, 2), 15);

    // Oversize source width and target sizes clamp to the maximum; only the
    // start of this large frame is requested.
    run_phase(13'h1FFF, 13'd1, 13'd8191, 13'd8191, 1'b0, 1, 2, 150);

    start_i = 1'b0;
    while (pending_pixels != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (fail_count == 0 && pending_pixels == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
